FILE: rtl/vpa_pkg.sv
// Shared widths, limits, codes and command types of the vehicle PID actuator.
package vpa_pkg;

   // Field widths of the request, result and register beats.
   localparam int SPEED_W = 15;
   localparam int HEAD_W  = 16;
   localparam int GAIN_W  = 16;
   localparam int THR_W   = 15;
   localparam int BRK_W   = 16;
   localparam int STR_W   = 16;

   // Configuration port.
   localparam int NUM_REGS = 6;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] REG_SPEED_P = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_I = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_D = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_STEER_P = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_STEER_I = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_STEER_D = 3'd5;

   // Default control tick rate in ticks per second (supported range 1 to 1000).
   localparam int TICK_RATE_DEF = 20;

   // Divider: the widest dividend is |now - target| shifted up by 12 bits.
   localparam int DIV_W  = 27;
   localparam int DIVR_W = 15;
   localparam int CNT_W  = $clog2(DIV_W);

   // Reciprocal of the tick rate used for the integral steps; it stays below
   // 2^25 for every supported rate.
   localparam int RECIP_W = 26;

   // Internal datapath widths.
   localparam int ERR_W   = 16;
   localparam int SSUM_W  = 24;
   localparam int HSUM_W  = 32;
   localparam int MULA_W  = 17;
   localparam int MULB_W  = 32;
   localparam int PROD_W  = MULA_W + MULB_W;
   localparam int ACC_W   = 48;

   // Saturation limits.
   localparam int ERR_MAX      = 32767;
   localparam int ERR_MIN      = -32768;
   localparam int SSUM_LIMIT   = 5242880;
   localparam int THROTTLE_CAP = 22938;
   localparam int BRAKE_CAP    = 32768;
   localparam int STEER_CAP    = 26214;

   // Division jobs, in the order the sequencer runs them.
   typedef enum logic [1:0] {
      DIV_SERR  = 2'd0,
      DIV_SSTEP = 2'd1,
      DIV_HSTEP = 2'd2
   } div_sel_type;

   // Multiply and accumulate steps, in the order the sequencer runs them.
   typedef enum logic [2:0] {
      OP_DLT_S = 3'd0,
      OP_P_S   = 3'd1,
      OP_I_S   = 3'd2,
      OP_D_S   = 3'd3,
      OP_DLT_H = 3'd4,
      OP_P_H   = 3'd5,
      OP_I_H   = 3'd6,
      OP_D_H   = 3'd7
   } op_type;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic        capture;
      logic        div_load;
      logic        div_step;
      logic        div_end;
      div_sel_type div_sel;
      logic        mul_go;
      logic        acc_go;
      op_type      op;
      logic        finish;
   } cmd_type;

   // Status from the datapath to the sequencer.
   typedef struct packed {
      logic out_free;
   } status_type;

   // Magnitude of a signed 16-bit value; the most negative value maps to 32768.
   function automatic logic [ERR_W-1:0] abs16(input logic signed [ERR_W-1:0] x);
      logic signed [ERR_W-1:0] n;
      n = -x;
      return x[ERR_W-1] ? ERR_W'(n) : ERR_W'(x);
   endfunction

endpackage

FILE: rtl/vpa_if.sv
// Request and response channel interfaces of the vehicle PID actuator.
interface vpa_req_if;
   import vpa_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [SPEED_W-1:0]        speed_now;
   logic [SPEED_W-1:0]        speed_target;
   logic signed [HEAD_W-1:0]  heading_error;

   modport source (output valid, speed_now, speed_target, heading_error, input ready);
   modport sink (input valid, speed_now, speed_target, heading_error, output ready);
endinterface

interface vpa_rsp_if;
   import vpa_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [THR_W-1:0]          throttle_cmd;
   logic [BRK_W-1:0]          brake_cmd;
   logic signed [STR_W-1:0]   steer_cmd;

   modport source (output valid, throttle_cmd, brake_cmd, steer_cmd, input ready);
   modport sink (input valid, throttle_cmd, brake_cmd, steer_cmd, output ready);
endinterface

FILE: rtl/vehicle_pid_actuator_core.sv
// Vehicle PID actuator: speed and heading PID laws giving throttle, brake and steering.
//
// Usage:
// - req_chan carries one control tick per beat: measured speed, target speed
//   (both unsigned Q7.8) and heading error (signed Q3.12).
// - rsp_chan returns one beat per tick: throttle (Q0.15) and brake (Q1.15),
//   only one of them nonzero, and steering (signed Q0.15, within plus or minus 0.8).
// - csr_wr_en, csr_index and csr_wdata write the six signed Q8.8 gains; write
//   them only while no tick is in flight.
// - A tick runs from its request beat to its response valid through a 27-bit
//   restoring division of the speed error, then the two integral steps by
//   reciprocal multiplication, then eight multiply and accumulate steps on
//   the shared 17 by 32 bit multiplier, then, once the result register is
//   free, the load of the result register. One tick is taken at a time: a new
//   request beat is accepted only after the previous tick has loaded its result.
// - The result register holds a finished beat while rsp_chan is stalled; the
//   next tick is taken meanwhile and waits, done, until the register frees.
// - Reset clears the gains, both integrals and the previous errors, and empties
//   the result register.
module vehicle_pid_actuator_core #(
   parameter int TICK_RATE = vpa_pkg::TICK_RATE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   vpa_req_if.sink                       req_chan,
   vpa_rsp_if.source                     rsp_chan,
   input  logic                          csr_wr_en,
   input  logic [vpa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [vpa_pkg::GAIN_W-1:0]    csr_wdata
);
   import vpa_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   // Sequencer.
   vpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath.
   vpa_dp #(
      .TICK_RATE (TICK_RATE)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .speed_now     (req_chan.speed_now),
      .speed_target  (req_chan.speed_target),
      .heading_error (req_chan.heading_error),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_ready     (rsp_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .throttle_cmd  (rsp_chan.throttle_cmd),
      .brake_cmd     (rsp_chan.brake_cmd),
      .steer_cmd     (rsp_chan.steer_cmd)
   );

   assign req_chan.ready = req_ready;

   // A request beat starts a tick; no second beat is taken in the next cycle.
   a_one_tick_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("request taken while a tick was in flight");

   // Throttle and brake are never demanded together.
   a_thr_brk_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.throttle_cmd == '0) || (rsp_chan.brake_cmd == '0))
      else $error("throttle and brake both nonzero");

   // Commands stay inside their caps.
   a_caps: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.throttle_cmd <= THR_W'(THROTTLE_CAP))
                      && (rsp_chan.brake_cmd <= BRK_W'(BRAKE_CAP))
                      && (rsp_chan.steer_cmd <= STEER_CAP)
                      && (rsp_chan.steer_cmd >= -STEER_CAP))
      else $error("command beyond its cap");

   // A new result is never produced in the cycle right after a request beat.
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready && !rsp_chan.valid |=> !rsp_chan.valid)
      else $error("result appeared without computation");

endmodule

FILE: rtl/vpa_ctrl.sv
// Sequencer of the vehicle PID actuator: steps the divider and the multiplier.
module vpa_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  vpa_pkg::status_type status,
   output vpa_pkg::cmd_type   cmd
);
   import vpa_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_DLOAD = 7'b0000010,
      S_DRUN  = 7'b0000100,
      S_DEND  = 7'b0001000,
      S_MUL   = 7'b0010000,
      S_ACC   = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type   state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   div_sel_type sel_ff, sel_in;
   op_type      op_ff, op_in;

   // Next state and command decode.
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      sel_in      = sel_ff;
      op_in       = op_ff;
      req_ready   = 1'b0;
      cmd         = '0;
      cmd.div_sel = sel_ff;
      cmd.op      = op_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               sel_in      = DIV_SERR;
               state_in    = S_DLOAD;
            end
         end
         S_DLOAD: begin
            // Only the speed error needs the bit-serial divider; the integral
            // steps are finished by the load itself.
            cmd.div_load = 1'b1;
            cnt_in       = CNT_W'(DIV_W - 1);
            if (sel_ff == DIV_SERR) begin
               state_in = S_DRUN;
            end else begin
               state_in = S_DEND;
            end
         end
         S_DRUN: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_DEND;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_DEND: begin
            cmd.div_end = 1'b1;
            case (sel_ff)
               DIV_SERR: begin
                  sel_in   = DIV_SSTEP;
                  state_in = S_DLOAD;
               end
               DIV_SSTEP: begin
                  sel_in   = DIV_HSTEP;
                  state_in = S_DLOAD;
               end
               default: begin
                  op_in    = OP_DLT_S;
                  state_in = S_MUL;
               end
            endcase
         end
         S_MUL: begin
            cmd.mul_go = 1'b1;
            state_in   = S_ACC;
         end
         S_ACC: begin
            cmd.acc_go = 1'b1;
            if (op_ff == OP_D_H) begin
               state_in = S_DONE;
            end else begin
               op_in    = op_type'(op_ff + 3'd1);
               state_in = S_MUL;
            end
         end
         S_DONE: begin
            // Wait here while the previous result beat is still unclaimed.
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         sel_ff   <= DIV_SERR;
         op_ff    <= OP_DLT_S;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         sel_ff   <= sel_in;
         op_ff    <= op_in;
      end
   end

endmodule

FILE: rtl/vpa_dp.sv
// Datapath of the vehicle PID actuator: gains, state, divider, multiplier, result.
module vpa_dp #(
   parameter int TICK_RATE = vpa_pkg::TICK_RATE_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  vpa_pkg::cmd_type                      cmd,
   output vpa_pkg::status_type                   status,
   input  logic [vpa_pkg::SPEED_W-1:0]           speed_now,
   input  logic [vpa_pkg::SPEED_W-1:0]           speed_target,
   input  logic signed [vpa_pkg::HEAD_W-1:0]     heading_error,
   input  logic                                  csr_wr_en,
   input  logic [vpa_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [vpa_pkg::GAIN_W-1:0]            csr_wdata,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic [vpa_pkg::THR_W-1:0]             throttle_cmd,
   output logic [vpa_pkg::BRK_W-1:0]             brake_cmd,
   output logic signed [vpa_pkg::STR_W-1:0]      steer_cmd
);
   import vpa_pkg::*;

   localparam int TickEff = (TICK_RATE < 1) ? 1 : TICK_RATE;
   localparam logic signed [MULB_W-1:0] TickMul = MULB_W'(TickEff);

   // Reciprocal of the tick rate, rounded up, with enough fraction bits that
   // magnitude * 256 / rate is exact for every magnitude up to 32768.
   localparam int RecipShift = 24 + $clog2(TickEff);
   localparam int StepShift  = RecipShift - 8;
   localparam logic [RECIP_W-1:0] TickRecip =
      RECIP_W'(((64'd1 << RecipShift) + 64'(TickEff) - 64'd1) / 64'(TickEff));

   // Configuration registers.
   logic signed [GAIN_W-1:0] gain_ff [NUM_REGS];

   // Loop state.
   logic signed [ERR_W-1:0]  last_s_ff, last_s_in;
   logic signed [ERR_W-1:0]  last_h_ff, last_h_in;
   logic signed [SSUM_W-1:0] ssum_ff, ssum_in;
   logic signed [HSUM_W-1:0] hsum_ff, hsum_in;

   // Per-tick working registers.
   logic signed [ERR_W-1:0]  diff_ff, diff_in;
   logic [SPEED_W-1:0]       tgt_ff, tgt_in;
   logic signed [HEAD_W-1:0] head_ff, head_in;
   logic signed [ERR_W-1:0]  serr_ff, serr_in;
   logic [DIV_W-1:0]         quo_ff, quo_in;
   logic [DIVR_W-1:0]        rem_ff, rem_in;
   logic [DIVR_W-1:0]        dvs_ff, dvs_in;
   logic                     neg_ff, neg_in;
   logic                     zero_ff, zero_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [MULB_W-1:0] dterm_ff, dterm_in;
   logic signed [ACC_W-1:0]  lon_ff, lon_in;
   logic signed [ACC_W-1:0]  lat_ff, lat_in;

   // Result register.
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [THR_W-1:0]         thr_ff, thr_in;
   logic [BRK_W-1:0]         brk_ff, brk_in;
   logic signed [STR_W-1:0]  str_ff, str_in;

   // Divider step: one quotient bit a cycle, restoring.
   logic [DIVR_W:0]          div_shl;
   logic                     div_ge;
   logic [DIVR_W-1:0]        rem_step;
   logic [DIV_W-1:0]         quo_step;

   assign div_shl  = {rem_ff, quo_ff[DIV_W-1]};
   assign div_ge   = div_shl >= {1'b0, dvs_ff};
   assign rem_step = div_ge ? DIVR_W'(div_shl - {1'b0, dvs_ff}) : div_shl[DIVR_W-1:0];
   assign quo_step = {quo_ff[DIV_W-2:0], div_ge};

   // Signed quotient and the three ways it is used.
   logic signed [DIV_W:0]    quo_signed;
   logic signed [ERR_W-1:0]  serr_div;
   logic signed [SSUM_W+1:0] ssum_sum;
   logic signed [HSUM_W:0]   hsum_sum;
   logic [ERR_W-1:0]         serr_mag;
   logic [ERR_W-1:0]         head_mag;
   logic [ERR_W-1:0]         diff_mag;

   assign quo_signed = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   assign serr_mag   = abs16(serr_ff);
   assign head_mag   = abs16(head_ff);
   assign diff_mag   = abs16(diff_ff);
   assign ssum_sum   = (SSUM_W + 2)'(ssum_ff) + (SSUM_W + 2)'(quo_signed);
   assign hsum_sum   = (HSUM_W + 1)'(hsum_ff) + (HSUM_W + 1)'(quo_signed);

   // Integral step magnitude: |error| * 256 / rate, truncated, by reciprocal.
   logic [ERR_W-1:0]         step_mag;
   logic [ERR_W+RECIP_W-1:0] step_prod;
   logic [DIV_W-1:0]         step_quo;

   assign step_mag  = (cmd.div_sel == DIV_SSTEP) ? serr_mag : head_mag;
   assign step_prod = (ERR_W + RECIP_W)'(step_mag) * (ERR_W + RECIP_W)'(TickRecip);
   assign step_quo  = DIV_W'(step_prod >> StepShift);

   always_comb begin
      if (zero_ff) begin
         serr_div = '0;
      end else if (quo_ff > DIV_W'(ERR_MAX)) begin
         serr_div = neg_ff ? ERR_W'(ERR_MIN) : ERR_W'(ERR_MAX);
      end else begin
         serr_div = ERR_W'(quo_signed);
      end
   end

   // Shared multiplier operand selection.
   logic signed [MULA_W-1:0] mul_a;
   logic signed [MULB_W-1:0] mul_b;
   logic signed [PROD_W-1:0] prod_frac;

   always_comb begin
      case (cmd.op)
         OP_DLT_S: begin
            mul_a = MULA_W'(serr_ff) - MULA_W'(last_s_ff);
            mul_b = TickMul;
         end
         OP_P_S: begin
            mul_a = MULA_W'(gain_ff[REG_SPEED_P]);
            mul_b = MULB_W'(serr_ff);
         end
         OP_I_S: begin
            mul_a = MULA_W'(gain_ff[REG_SPEED_I]);
            mul_b = MULB_W'(ssum_ff);
         end
         OP_D_S: begin
            mul_a = MULA_W'(gain_ff[REG_SPEED_D]);
            mul_b = dterm_ff;
         end
         OP_DLT_H: begin
            mul_a = MULA_W'(head_ff) - MULA_W'(last_h_ff);
            mul_b = TickMul;
         end
         OP_P_H: begin
            mul_a = MULA_W'(gain_ff[REG_STEER_P]);
            mul_b = MULB_W'(head_ff);
         end
         OP_I_H: begin
            mul_a = MULA_W'(gain_ff[REG_STEER_I]);
            mul_b = hsum_ff;
         end
         default: begin
            mul_a = MULA_W'(gain_ff[REG_STEER_D]);
            mul_b = dterm_ff;
         end
      endcase
   end

   assign prod_frac = prod_ff >>> 8;

   // Result shaping: Q.20 sums to Q0.15 commands with caps.
   logic signed [ACC_W-1:0] lon_neg;
   logic signed [ACC_W-1:0] thr_sh;
   logic signed [ACC_W-1:0] brk_sh;
   logic signed [ACC_W-1:0] str_sh;
   logic [THR_W-1:0]        thr_val;
   logic [BRK_W-1:0]        brk_val;
   logic signed [STR_W-1:0] str_val;

   assign lon_neg = -lon_ff;
   assign thr_sh  = lon_neg >>> 5;
   assign brk_sh  = lon_ff >>> 5;
   assign str_sh  = lat_ff >>> 5;
   assign thr_val = (thr_sh > THROTTLE_CAP) ? THR_W'(THROTTLE_CAP) : THR_W'(thr_sh);
   assign brk_val = (brk_sh > BRAKE_CAP) ? BRK_W'(BRAKE_CAP) : BRK_W'(brk_sh);

   always_comb begin
      if (str_sh > STEER_CAP) begin
         str_val = STR_W'(STEER_CAP);
      end else if (str_sh < -STEER_CAP) begin
         str_val = STR_W'(-STEER_CAP);
      end else begin
         str_val = STR_W'(str_sh);
      end
   end

   // Next values of all datapath registers.
   always_comb begin
      last_s_in    = last_s_ff;
      last_h_in    = last_h_ff;
      ssum_in      = ssum_ff;
      hsum_in      = hsum_ff;
      diff_in      = diff_ff;
      tgt_in       = tgt_ff;
      head_in      = head_ff;
      serr_in      = serr_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      neg_in       = neg_ff;
      zero_in      = zero_ff;
      prod_in      = prod_ff;
      dterm_in     = dterm_ff;
      lon_in       = lon_ff;
      lat_in       = lat_ff;
      thr_in       = thr_ff;
      brk_in       = brk_ff;
      str_in       = str_ff;
      rsp_valid_in = rsp_valid_ff;

      // Capture the request beat.
      if (cmd.capture) begin
         diff_in = ERR_W'({1'b0, speed_now}) - ERR_W'({1'b0, speed_target});
         tgt_in  = speed_target;
         head_in = heading_error;
      end

      // Load the divider for the speed error, or the finished integral step.
      if (cmd.div_load) begin
         rem_in = '0;
         case (cmd.div_sel)
            DIV_SERR: begin
               quo_in  = {diff_mag[DIVR_W-1:0], 12'd0};
               dvs_in  = tgt_ff;
               neg_in  = diff_ff[ERR_W-1];
               zero_in = (diff_ff == '0);
            end
            DIV_SSTEP: begin
               quo_in  = step_quo;
               neg_in  = serr_ff[ERR_W-1];
               zero_in = 1'b0;
            end
            default: begin
               quo_in  = step_quo;
               neg_in  = head_ff[HEAD_W-1];
               zero_in = 1'b0;
            end
         endcase
      end

      if (cmd.div_step) begin
         quo_in = quo_step;
         rem_in = rem_step;
      end

      // Store the quotient: speed error, or an integral update with clamp.
      if (cmd.div_end) begin
         case (cmd.div_sel)
            DIV_SERR: begin
               serr_in = serr_div;
            end
            DIV_SSTEP: begin
               if (ssum_sum > SSUM_LIMIT) begin
                  ssum_in = SSUM_W'(SSUM_LIMIT);
               end else if (ssum_sum < -SSUM_LIMIT) begin
                  ssum_in = SSUM_W'(-SSUM_LIMIT);
               end else begin
                  ssum_in = SSUM_W'(ssum_sum);
               end
            end
            default: begin
               if (hsum_sum[HSUM_W] != hsum_sum[HSUM_W-1]) begin
                  hsum_in = hsum_sum[HSUM_W] ? {1'b1, {(HSUM_W-1){1'b0}}}
                                             : {1'b0, {(HSUM_W-1){1'b1}}};
               end else begin
                  hsum_in = HSUM_W'(hsum_sum);
               end
            end
         endcase
      end

      if (cmd.mul_go) begin
         prod_in = mul_a * mul_b;
      end

      // Fold the registered product into its law.
      if (cmd.acc_go) begin
         case (cmd.op)
            OP_DLT_S, OP_DLT_H: dterm_in = MULB_W'(prod_ff);
            OP_P_S:             lon_in   = ACC_W'(prod_ff);
            OP_I_S:             lon_in   = lon_ff + ACC_W'(prod_frac);
            OP_D_S:             lon_in   = lon_ff + ACC_W'(prod_ff);
            OP_P_H:             lat_in   = ACC_W'(prod_ff);
            OP_I_H:             lat_in   = lat_ff + ACC_W'(prod_frac);
            default:            lat_in   = lat_ff + ACC_W'(prod_ff);
         endcase
      end

      // Result beat leaves when taken; a new one is loaded only into a free slot.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         thr_in       = lon_ff[ACC_W-1] ? thr_val : '0;
         brk_in       = lon_ff[ACC_W-1] ? '0 : brk_val;
         str_in       = str_val;
         last_s_in    = serr_ff;
         last_h_in    = head_ff;
      end
   end

   // Control and loop state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         last_s_ff    <= '0;
         last_h_ff    <= '0;
         ssum_ff      <= '0;
         hsum_ff      <= '0;
         for (int i = 0; i < NUM_REGS; i++) begin
            gain_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         last_s_ff    <= last_s_in;
         last_h_ff    <= last_h_in;
         ssum_ff      <= ssum_in;
         hsum_ff      <= hsum_in;
         if (csr_wr_en && (csr_index < CSR_IDX_W'(NUM_REGS))) begin
            gain_ff[csr_index] <= csr_wdata;
         end
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      diff_ff  <= diff_in;
      tgt_ff   <= tgt_in;
      head_ff  <= head_in;
      serr_ff  <= serr_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
      neg_ff   <= neg_in;
      zero_ff  <= zero_in;
      prod_ff  <= prod_in;
      dterm_ff <= dterm_in;
      lon_ff   <= lon_in;
      lat_ff   <= lat_in;
      thr_ff   <= thr_in;
      brk_ff   <= brk_in;
      str_ff   <= str_in;
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign throttle_cmd    = thr_ff;
   assign brake_cmd       = brk_ff;
   assign steer_cmd       = str_ff;

endmodule
